FILE: hw/rtl/brs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear relief sampler package
// Shared codes, register indexes, fixed-point constants and the item type.
// ----------------------------------------------------------------------------
package brs_pkg;

   // Operation codes of an input word
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Relief modes; the spare code acts as zero relief
   localparam logic [1:0] MODE_ZERO  = 2'd0;
   localparam logic [1:0] MODE_IMAGE = 2'd1;
   localparam logic [1:0] MODE_NOISE = 2'd2;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_RELIEF_MODE  = 3'd0;
   localparam logic [2:0] REG_COORD_SCALE  = 3'd1;
   localparam logic [2:0] REG_DEPTH_STEP   = 3'd2;
   localparam logic [2:0] REG_TEX_WIDTH    = 3'd3;
   localparam logic [2:0] REG_TEX_HEIGHT   = 3'd4;
   localparam logic [2:0] REG_INVERT_DEPTH = 3'd5;
   localparam logic [2:0] REG_KEEP_VERT    = 3'd6;
   localparam logic [2:0] REG_MIRROR_HORZ  = 3'd7;

   // Fraction bits of a texel (Q1.14) and the relief saturation bound
   localparam int TEXEL_FRAC = 14;
   localparam int RELIEF_MAX = 196608;

   // Remainder bits resolved per stage of the wrap unit
   localparam int MOD_STEPS = 4;

   localparam logic [8:0] SIZE_MAX = 9'd256;

   typedef struct packed {
      logic               opcode;
      logic [15:0]        texel_addr;
      logic signed [15:0] texel_value;
      logic [21:0]        pixel_index;
      logic               last_in_batch;
   } item_type;

   // Bring a texture dimension into 1..256
   function automatic logic [8:0] clamp_size(input logic [8:0] s);
      logic [8:0] r;
      r = s;
      if (s == 9'd0) begin
         r = 9'd1;
      end else if (s > SIZE_MAX) begin
         r = SIZE_MAX;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/wrapped_bilinear_relief_sampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapped bilinear relief sampler
// Texture store, wrapped bilinear sampling and relief depth mapping.
// ----------------------------------------------------------------------------
// One word enters per clock: busy stays low, so every cycle with start high
// takes a load or a sample word. A sample gives its result strobe once it
// has passed every stage of the chain below; a load gives none. The wrap
// unit is MOD_STAGES = ceil((min(COORD_BITS,12)+8)/4) stages deep. The
// strobe is high for exactly one cycle and the receiver cannot hold it, so
// it must take every word as it comes. The stage chain is: capture, scale
// multiply, wrap remainder (four bits per stage), mirror and neighbor
// select, row multiply, texture read, two interpolation multiplies, invert
// and mode operand, depth multiply split in two partial products, rounding
// and saturation. The texture lives in two copies of the store, each read
// at two addresses per cycle; loads walk down the pipeline and write both
// copies at the read stage, so a sample always sees every load taken
// before it. The store is not cleared after reset: read only texels that
// were loaded. Write configuration only while no word is in flight.
// ----------------------------------------------------------------------------
module wrapped_bilinear_relief_sampler_core #(
   parameter int TEXTURE_WORDS = 65536,
   parameter int COORD_BITS    = 12,
   parameter int FRAC_BITS     = 8
) (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic [15:0]        req_texel_addr,
   input  logic signed [15:0] req_texel_value,
   input  logic [21:0]        req_pixel_index,
   input  logic [11:0]        req_pixel_x,
   input  logic [11:0]        req_pixel_y,
   input  logic               req_last_in_batch,
   // result channel
   output logic               rsp_strobe,
   output logic [21:0]        rsp_out_index,
   output logic signed [18:0] rsp_relief_value,
   output logic               rsp_batch_done,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int F    = FRAC_BITS;
   localparam int PB   = (COORD_BITS < 12) ? COORD_BITS : 12; // used coordinate bits
   localparam int PW   = PB + 16;                               // scaled coordinate
   localparam int NW   = PW - 8;                                // integer texel part
   localparam int MOD_STAGES = (NW + brs_pkg::MOD_STEPS - 1) / brs_pkg::MOD_STEPS;
   localparam int CS   = brs_pkg::TEXEL_FRAC + 2 * F;           // fraction bits of c
   localparam int WW   = F + 1;                                 // weight width
   localparam int TW   = 17 + F;                                // row blend width
   localparam int CW   = TW + F + 1;                            // c width
   localparam int AW2  = CW + 2;                                // depth operand width
   localparam int HW   = AW2 - 17;                              // upper partial operand
   localparam int PWID = AW2 + 18;                              // depth product width
   localparam int RW   = PWID - CS;                             // rounded depth width
   localparam int AW   = (TEXTURE_WORDS > 1) ? $clog2(TEXTURE_WORDS) : 1;
   localparam int XW   = (AW > 17) ? AW : 17;
   localparam int LAT  = MOD_STAGES + 11;

   localparam logic [WW-1:0]          ONE_F = WW'(1) << F;
   localparam logic signed [AW2-1:0]  ONE_C = AW2'(1) << CS;
   localparam logic signed [PWID-1:0] HALF  = PWID'(1) << (CS - 1);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [1:0]  relief_mode_ff;
   logic [15:0] coord_scale_ff;
   logic [15:0] depth_step_ff;
   logic [8:0]  tex_width_ff;
   logic [8:0]  tex_height_ff;
   logic        invert_depth_ff;
   logic        keep_vertical_ff;
   logic        mirror_horizontal_ff;
   logic        cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         relief_mode_ff       <= brs_pkg::MODE_ZERO;
         coord_scale_ff       <= 16'd256;
         depth_step_ff        <= 16'd256;
         tex_width_ff         <= 9'd64;
         tex_height_ff        <= 9'd64;
         invert_depth_ff      <= 1'b0;
         keep_vertical_ff     <= 1'b0;
         mirror_horizontal_ff <= 1'b0;
      end else if (cfg_wr) begin
         case (paddr[4:2])
            brs_pkg::REG_RELIEF_MODE:  relief_mode_ff       <= pwdata[1:0];
            brs_pkg::REG_COORD_SCALE:  coord_scale_ff       <= pwdata[15:0];
            brs_pkg::REG_DEPTH_STEP:   depth_step_ff        <= pwdata[15:0];
            brs_pkg::REG_TEX_WIDTH:    tex_width_ff         <= pwdata[8:0];
            brs_pkg::REG_TEX_HEIGHT:   tex_height_ff        <= pwdata[8:0];
            brs_pkg::REG_INVERT_DEPTH: invert_depth_ff      <= pwdata[0];
            brs_pkg::REG_KEEP_VERT:    keep_vertical_ff     <= pwdata[0];
            brs_pkg::REG_MIRROR_HORZ:  mirror_horizontal_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         brs_pkg::REG_RELIEF_MODE:  prdata = 32'(relief_mode_ff);
         brs_pkg::REG_COORD_SCALE:  prdata = 32'(coord_scale_ff);
         brs_pkg::REG_DEPTH_STEP:   prdata = 32'(depth_step_ff);
         brs_pkg::REG_TEX_WIDTH:    prdata = 32'(tex_width_ff);
         brs_pkg::REG_TEX_HEIGHT:   prdata = 32'(tex_height_ff);
         brs_pkg::REG_INVERT_DEPTH: prdata = 32'(invert_depth_ff);
         brs_pkg::REG_KEEP_VERT:    prdata = 32'(keep_vertical_ff);
         brs_pkg::REG_MIRROR_HORZ:  prdata = 32'(mirror_horizontal_ff);
         default:                   prdata = '0;
      endcase
   end

   // Effective texture size; the user must keep it static while words are in flight, the block does not enforce it
   logic [8:0] size_w;
   logic [8:0] size_h;

   assign size_w = brs_pkg::clamp_size(tex_width_ff);
   assign size_h = brs_pkg::clamp_size(tex_height_ff);

   // ------------------------------------------------------------------------
   // Stage 0: capture the word
   // ------------------------------------------------------------------------
   logic              accept;
   logic              s0_v_ff;
   brs_pkg::item_type s0_item_ff;
   logic [11:0]       s0_x_ff;
   logic [11:0]       s0_y_ff;

   // no back pressure anywhere: take a word in every cycle
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else begin
         s0_v_ff <= accept;
      end
      s0_item_ff <= '{opcode: req_opcode, texel_addr: req_texel_addr,
                      texel_value: req_texel_value, pixel_index: req_pixel_index,
                      last_in_batch: req_last_in_batch};
      s0_x_ff    <= req_pixel_x;
      s0_y_ff    <= req_pixel_y;
   end

   // ------------------------------------------------------------------------
   // Stage 1: scale both coordinates (Q8.8 factor)
   // ------------------------------------------------------------------------
   logic              s1_v_ff;
   brs_pkg::item_type s1_item_ff;
   logic [PW-1:0]     s1_px_ff;
   logic [PW-1:0]     s1_py_ff;
   logic [PW-1:0]     px_in;
   logic [PW-1:0]     py_in;

   assign px_in = PW'(s0_x_ff[PB-1:0]) * PW'(coord_scale_ff);
   assign py_in = PW'(s0_y_ff[PB-1:0]) * PW'(coord_scale_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s0_v_ff;
      end
      s1_item_ff <= s0_item_ff;
      s1_px_ff   <= px_in;
      s1_py_ff   <= py_in;
   end

   // Fraction: low F bits of (scaled << F) >> 8
   logic [PW+F-1:0] xs_ext;
   logic [PW+F-1:0] ys_ext;
   logic [F-1:0]    frac_x;
   logic [F-1:0]    frac_y;

   assign xs_ext = {s1_px_ff, F'(0)};
   assign ys_ext = {s1_py_ff, F'(0)};
   assign frac_x = xs_ext[F+7:8];
   assign frac_y = ys_ext[F+7:8];

   // ------------------------------------------------------------------------
   // Wrap: integer part modulo size; side data rides a matching delay line
   // ------------------------------------------------------------------------
   logic [7:0] rem_x;
   logic [7:0] rem_y;

   brs_mod #(.NW(NW)) u_mod_x (
      .clock (clock),
      .num   (s1_px_ff[PW-1:8]),
      .size  (size_w),
      .rem   (rem_x)
   );

   brs_mod #(.NW(NW)) u_mod_y (
      .clock (clock),
      .num   (s1_py_ff[PW-1:8]),
      .size  (size_h),
      .rem   (rem_y)
   );

   logic              dl_v_ff    [MOD_STAGES];
   brs_pkg::item_type dl_item_ff [MOD_STAGES];
   logic [F-1:0]      dl_fx_ff   [MOD_STAGES];
   logic [F-1:0]      dl_fy_ff   [MOD_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MOD_STAGES; i++) begin
            dl_v_ff[i] <= 1'b0;
         end
      end else begin
         dl_v_ff[0] <= s1_v_ff;
         for (int i = 1; i < MOD_STAGES; i++) begin
            dl_v_ff[i] <= dl_v_ff[i-1];
         end
      end
      dl_item_ff[0] <= s1_item_ff;
      dl_fx_ff[0]   <= frac_x;
      dl_fy_ff[0]   <= frac_y;
      for (int i = 1; i < MOD_STAGES; i++) begin
         dl_item_ff[i] <= dl_item_ff[i-1];
         dl_fx_ff[i]   <= dl_fx_ff[i-1];
         dl_fy_ff[i]   <= dl_fy_ff[i-1];
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: mirror, pick the low and clamped high neighbor
   // ------------------------------------------------------------------------
   // Mirror of a wrapped value u is span - u, or zero when u is zero.
   function automatic logic [8+F-1:0] fold(input logic [7:0] ri, input logic [F-1:0] fi,
                                           input logic [8:0] sz, input logic mir);
      logic [8:0]   li;
      logic [F-1:0] fo;
      li = {1'b0, ri};
      fo = fi;
      if (mir && (ri != 8'd0 || fi != '0)) begin
         if (fi == '0) begin
            li = sz - {1'b0, ri};
         end else begin
            li = sz - {1'b0, ri} - 9'd1;
            fo = F'(ONE_F - {1'b0, fi});
         end
      end
      return {li[7:0], fo};
   endfunction

   function automatic logic [7:0] upper(input logic [7:0] li, input logic [8:0] sz);
      logic [8:0] nx;
      nx = {1'b0, li} + 9'd1;
      if (nx >= sz) begin
         nx = sz - 9'd1;
      end
      return nx[7:0];
   endfunction

   logic [8+F-1:0]    fold_x;
   logic [8+F-1:0]    fold_y;
   logic              s2_v_ff;
   brs_pkg::item_type s2_item_ff;
   logic [7:0]        s2_lx_ff;
   logic [7:0]        s2_hx_ff;
   logic [7:0]        s2_ly_ff;
   logic [7:0]        s2_hy_ff;
   logic [F-1:0]      s2_fx_ff;
   logic [F-1:0]      s2_fy_ff;

   assign fold_x = fold(rem_x, dl_fx_ff[MOD_STAGES-1], size_w, mirror_horizontal_ff);
   assign fold_y = fold(rem_y, dl_fy_ff[MOD_STAGES-1], size_h, ~keep_vertical_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= dl_v_ff[MOD_STAGES-1];
      end
      s2_item_ff <= dl_item_ff[MOD_STAGES-1];
      s2_lx_ff   <= fold_x[8+F-1:F];
      s2_hx_ff   <= upper(fold_x[8+F-1:F], size_w);
      s2_fx_ff   <= fold_x[F-1:0];
      s2_ly_ff   <= fold_y[8+F-1:F];
      s2_hy_ff   <= upper(fold_y[8+F-1:F], size_h);
      s2_fy_ff   <= fold_y[F-1:0];
   end

   // ------------------------------------------------------------------------
   // Stage 3: row base addresses
   // ------------------------------------------------------------------------
   logic              s3_v_ff;
   brs_pkg::item_type s3_item_ff;
   logic [16:0]       s3_rl_ff;
   logic [16:0]       s3_rh_ff;
   logic [7:0]        s3_lx_ff;
   logic [7:0]        s3_hx_ff;
   logic [F-1:0]      s3_fx_ff;
   logic [F-1:0]      s3_fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s2_v_ff;
      end
      s3_item_ff <= s2_item_ff;
      s3_rl_ff   <= 17'(s2_ly_ff) * 17'(size_w);
      s3_rh_ff   <= 17'(s2_hy_ff) * 17'(size_w);
      s3_lx_ff   <= s2_lx_ff;
      s3_hx_ff   <= s2_hx_ff;
      s3_fx_ff   <= s2_fx_ff;
      s3_fy_ff   <= s2_fy_ff;
   end

   // ------------------------------------------------------------------------
   // Texture access: loads write both copies here, samples read four texels
   // ------------------------------------------------------------------------
   function automatic logic [AW-1:0] ram_addr(input logic [16:0] a);
      logic [XW-1:0] e;
      e = XW'(a);
      return e[AW-1:0];
   endfunction

   logic [16:0]   a_ll;
   logic [16:0]   a_lh;
   logic [16:0]   a_hl;
   logic [16:0]   a_hh;
   logic [3:0]    ok_in;
   logic          wr_en;
   logic [15:0]   rd_ll;
   logic [15:0]   rd_lh;
   logic [15:0]   rd_hl;
   logic [15:0]   rd_hh;

   assign a_ll = s3_rl_ff + 17'(s3_lx_ff);
   assign a_lh = s3_rl_ff + 17'(s3_hx_ff);
   assign a_hl = s3_rh_ff + 17'(s3_lx_ff);
   assign a_hh = s3_rh_ff + 17'(s3_hx_ff);

   assign ok_in = {32'(a_hh) < TEXTURE_WORDS, 32'(a_hl) < TEXTURE_WORDS,
                   32'(a_lh) < TEXTURE_WORDS, 32'(a_ll) < TEXTURE_WORDS};

   // drop loads beyond the store
   assign wr_en = s3_v_ff && (s3_item_ff.opcode == brs_pkg::OP_LOAD) &&
                  (32'(s3_item_ff.texel_addr) < TEXTURE_WORDS);

   brs_ram #(.WIDTH(16), .DEPTH(TEXTURE_WORDS)) u_ram_top (
      .clock   (clock),
      .we      (wr_en),
      .waddr   (ram_addr(17'(s3_item_ff.texel_addr))),
      .wdata   (s3_item_ff.texel_value),
      .raddr_a (ram_addr(a_ll)),
      .raddr_b (ram_addr(a_lh)),
      .rdata_a (rd_ll),
      .rdata_b (rd_lh)
   );

   brs_ram #(.WIDTH(16), .DEPTH(TEXTURE_WORDS)) u_ram_bot (
      .clock   (clock),
      .we      (wr_en),
      .waddr   (ram_addr(17'(s3_item_ff.texel_addr))),
      .wdata   (s3_item_ff.texel_value),
      .raddr_a (ram_addr(a_hl)),
      .raddr_b (ram_addr(a_hh)),
      .rdata_a (rd_hl),
      .rdata_b (rd_hh)
   );

   // Stage 4: read data arrives with these; only samples go on from here
   logic              s4_v_ff;
   brs_pkg::item_type s4_item_ff;
   logic [3:0]        s4_ok_ff;
   logic [F-1:0]      s4_fx_ff;
   logic [F-1:0]      s4_fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else begin
         s4_v_ff <= s3_v_ff && (s3_item_ff.opcode == brs_pkg::OP_SAMPLE);
      end
      s4_item_ff <= s3_item_ff;
      s4_ok_ff   <= ok_in;
      s4_fx_ff   <= s3_fx_ff;
      s4_fy_ff   <= s3_fy_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 5: blend along x for the top and bottom rows
   // ------------------------------------------------------------------------
   logic signed [15:0]   t_ll;
   logic signed [15:0]   t_lh;
   logic signed [15:0]   t_hl;
   logic signed [15:0]   t_hh;
   logic signed [TW-1:0] wlx_s;
   logic signed [TW-1:0] whx_s;
   logic signed [TW-1:0] top_in;
   logic signed [TW-1:0] bot_in;
   logic                 s5_v_ff;
   brs_pkg::item_type    s5_item_ff;
   logic signed [TW-1:0] s5_top_ff;
   logic signed [TW-1:0] s5_bot_ff;
   logic [F-1:0]         s5_fy_ff;

   // texels outside the store read as zero
   assign t_ll   = s4_ok_ff[0] ? $signed(rd_ll) : 16'sd0;
   assign t_lh   = s4_ok_ff[1] ? $signed(rd_lh) : 16'sd0;
   assign t_hl   = s4_ok_ff[2] ? $signed(rd_hl) : 16'sd0;
   assign t_hh   = s4_ok_ff[3] ? $signed(rd_hh) : 16'sd0;
   assign wlx_s  = TW'(ONE_F - {1'b0, s4_fx_ff});
   assign whx_s  = TW'(s4_fx_ff);
   assign top_in = TW'(t_ll) * wlx_s + TW'(t_lh) * whx_s;
   assign bot_in = TW'(t_hl) * wlx_s + TW'(t_hh) * whx_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else begin
         s5_v_ff <= s4_v_ff;
      end
      s5_item_ff <= s4_item_ff;
      s5_top_ff  <= top_in;
      s5_bot_ff  <= bot_in;
      s5_fy_ff   <= s4_fy_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 6: blend along y
   // ------------------------------------------------------------------------
   logic signed [CW-1:0] wly_s;
   logic signed [CW-1:0] why_s;
   logic signed [CW-1:0] c_in;
   logic                 s6_v_ff;
   brs_pkg::item_type    s6_item_ff;
   logic signed [CW-1:0] s6_c_ff;

   assign wly_s = CW'(ONE_F - {1'b0, s5_fy_ff});
   assign why_s = CW'(s5_fy_ff);
   assign c_in  = CW'(s5_top_ff) * wly_s + CW'(s5_bot_ff) * why_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else begin
         s6_v_ff <= s5_v_ff;
      end
      s6_item_ff <= s5_item_ff;
      s6_c_ff    <= c_in;
   end

   // ------------------------------------------------------------------------
   // Stage 7: invert and form the mode operand
   // ------------------------------------------------------------------------
   logic signed [AW2-1:0] ci;
   logic signed [AW2-1:0] a_in;
   logic                  s7_v_ff;
   brs_pkg::item_type     s7_item_ff;
   logic signed [AW2-1:0] s7_a_ff;

   assign ci   = invert_depth_ff ? (ONE_C - AW2'(s6_c_ff)) : AW2'(s6_c_ff);
   // image relief works on 1 - 2c, noise relief on c
   assign a_in = (relief_mode_ff == brs_pkg::MODE_IMAGE) ? (ONE_C - (ci <<< 1)) : ci;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
      end else begin
         s7_v_ff <= s6_v_ff;
      end
      s7_item_ff <= s6_item_ff;
      s7_a_ff    <= a_in;
   end

   // ------------------------------------------------------------------------
   // Stage 8: depth step product as two partial products
   // ------------------------------------------------------------------------
   logic [16:0]              a_lo;
   logic signed [HW-1:0]     a_hi;
   logic signed [16:0]       step_s;
   logic                     s8_v_ff;
   brs_pkg::item_type        s8_item_ff;
   logic [32:0]              s8_pl_ff;
   logic signed [HW+16:0]    s8_ph_ff;

   assign a_lo   = s7_a_ff[16:0];
   assign a_hi   = s7_a_ff[AW2-1:17];
   assign step_s = {1'b0, depth_step_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_v_ff <= 1'b0;
      end else begin
         s8_v_ff <= s7_v_ff;
      end
      s8_item_ff <= s7_item_ff;
      s8_pl_ff   <= 33'(a_lo) * 33'(depth_step_ff);
      s8_ph_ff   <= (HW+17)'(a_hi) * (HW+17)'(step_s);
   end

   // ------------------------------------------------------------------------
   // Stage 9: join partial products, round to Q15.8 (ties up)
   // ------------------------------------------------------------------------
   logic signed [PWID-1:0] pl_s;
   logic signed [PWID-1:0] sum_in;
   logic                   s9_v_ff;
   brs_pkg::item_type      s9_item_ff;
   logic signed [RW-1:0]   s9_r_ff;

   assign pl_s   = PWID'(s8_pl_ff);
   assign sum_in = (PWID'(s8_ph_ff) <<< 17) + pl_s + HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_v_ff <= 1'b0;
      end else begin
         s9_v_ff <= s8_v_ff;
      end
      s9_item_ff <= s8_item_ff;
      s9_r_ff    <= sum_in[PWID-1:CS];
   end

   // ------------------------------------------------------------------------
   // Stage 10: saturate, apply mode, drive the result word
   // ------------------------------------------------------------------------
   logic signed [18:0] relief_in;
   logic               rsp_strobe_ff;
   logic [21:0]        rsp_index_ff;
   logic signed [18:0] rsp_value_ff;
   logic               rsp_done_ff;

   always_comb begin
      if (s9_r_ff > brs_pkg::RELIEF_MAX) begin
         relief_in = 19'(brs_pkg::RELIEF_MAX);
      end else if (s9_r_ff < -brs_pkg::RELIEF_MAX) begin
         relief_in = 19'(-brs_pkg::RELIEF_MAX);
      end else begin
         relief_in = s9_r_ff[18:0];
      end
      case (relief_mode_ff)
         brs_pkg::MODE_IMAGE, brs_pkg::MODE_NOISE: ;
         default: relief_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s9_v_ff;
      end
      rsp_index_ff <= s9_item_ff.pixel_index;
      rsp_value_ff <= relief_in;
      rsp_done_ff  <= s9_item_ff.last_in_batch;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_out_index    = rsp_index_ff;
   assign rsp_relief_value = rsp_value_ff;
   assign rsp_batch_done   = rsp_done_ff;

`ifndef SYNTH
   a_sample_gives_word: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == brs_pkg::OP_SAMPLE) |-> ##LAT rsp_strobe)
      else $error("sample word did not produce a result at the pipeline latency");

   a_load_is_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == brs_pkg::OP_LOAD) |-> ##LAT !rsp_strobe)
      else $error("load word produced a result");

   a_tags_follow: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == brs_pkg::OP_SAMPLE) |-> ##LAT
      (rsp_out_index == $past(req_pixel_index, LAT) &&
       rsp_batch_done == $past(req_last_in_batch, LAT)))
      else $error("result index or batch flag does not match its sample");

   a_relief_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_relief_value <= brs_pkg::RELIEF_MAX &&
                      rsp_relief_value >= -brs_pkg::RELIEF_MAX))
      else $error("relief value outside saturation range");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");
`endif

endmodule

FILE: hw/rtl/brs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear relief sampler RAM
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module brs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr_a,
   input  logic [AW-1:0]    raddr_b,
   output logic [WIDTH-1:0] rdata_a,
   output logic [WIDTH-1:0] rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_a_ff <= mem_ff[raddr_a];
      rd_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rd_a_ff;
   assign rdata_b = rd_b_ff;

endmodule

FILE: hw/rtl/brs_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear relief sampler wrap unit
// Pipelined restoring remainder of a coordinate by the texture size.
// ----------------------------------------------------------------------------
module brs_mod #(
   parameter int NW = 20
) (
   input  logic          clock,
   input  logic [NW-1:0] num,
   input  logic [8:0]    size,
   output logic [7:0]    rem
);

   localparam int MS = (NW + brs_pkg::MOD_STEPS - 1) / brs_pkg::MOD_STEPS;
   localparam int DW = MS * brs_pkg::MOD_STEPS;

   logic [8:0]    rem_ff [MS];
   logic [DW-1:0] dvd_ff [MS];
   logic [8:0]    rem_in [MS];
   logic [DW-1:0] dvd_in [MS];
   logic [8:0]    src_rem [MS];
   logic [DW-1:0] src_dvd [MS];

   for (genvar s = 0; s < MS; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign src_rem[s] = '0;
         assign src_dvd[s] = DW'(num);
      end else begin : g_next
         assign src_rem[s] = rem_ff[s-1];
         assign src_dvd[s] = dvd_ff[s-1];
      end

      // shift in one dividend bit per step, subtract the size when it fits
      always_comb begin
         logic [8:0]    r;
         logic [DW-1:0] d;
         r = src_rem[s];
         d = src_dvd[s];
         for (int k = 0; k < brs_pkg::MOD_STEPS; k++) begin
            r = {r[7:0], d[DW-1]};
            d = {d[DW-2:0], 1'b0};
            if (r >= size) begin
               r = r - size;
            end
         end
         rem_in[s] = r;
         dvd_in[s] = d;
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in[s];
         dvd_ff[s] <= dvd_in[s];
      end
   end

   assign rem = rem_ff[MS-1][7:0];

endmodule
